// ===== rtl/connection_handle_table_defines.svh =====
// Assertion macros for the connection handle table
`ifndef CONNECTION_HANDLE_TABLE_DEFINES_SVH
`define CONNECTION_HANDLE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("connection handle table check failed");
// Next-cycle implication, disabled while reset is asserted
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("connection handle table check failed");
`else
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/cht_pkg.sv =====
`default_nettype none

package cht_pkg;

    localparam int HANDLE_W = 12;
    localparam int ADDR_W   = 48;
    localparam int SLOT_W   = 5;

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // One stored entry; valid bits live in flip-flops outside the memory
    typedef struct packed {
        logic              low_energy;
        logic [ADDR_W-1:0] addr;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== rtl/connection_handle_table.sv =====
// Connection handle table.
// Input channel s_*: one item per command. s_tuser carries the operation
// (add or update, remove, lookup); s_tdata carries handle, device address
// and low-energy flag. Output channel m_*: one result item per command.
// m_tuser carries the status; m_tdata carries slot, stored address and flag.
// The table scans entries one at a time from index 0 through a single
// synchronous memory: each entry is read in S_READ, then compared in S_CHECK.
// The scan stops at the first match; a miss or an add of a new handle scans
// every entry. The reserved operation skips the scan and goes straight to
// S_FIN with its miss result.
// One command is in work at a time; s_tready is high while the scan engine
// is free, also while a finished result still waits on m_tready. A new
// result waits in the last step until the output register is free, so a
// stalled receiver stalls the table without losing results.
// Reset clears all valid bits at once (no clearing pass) and empties the
// output register; stored handles and addresses are used only for entries
// whose valid bit is set.
`default_nettype none

`include "connection_handle_table_defines.svh"

module connection_handle_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // handle[11:0], device_addr[59:12], low_energy[60]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // slot[4:0], addr_out[52:5], low_energy_out[53]
    output logic [1:0]       m_tuser   // status[1:0]
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    // control state
    logic [1:0]             r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic                   r_ovalid, n_ovalid;
    // command and scan payload
    logic [1:0]                     r_op, n_op;
    logic [cht_pkg::HANDLE_W-1:0]   r_key, n_key;
    logic [cht_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic                           r_le, n_le;
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_hit, n_hit;
    logic [IW-1:0]                  r_hit_idx, n_hit_idx;
    logic [cht_pkg::ADDR_W-1:0]     r_hit_addr, n_hit_addr;
    logic                           r_hit_le, n_hit_le;
    logic                           r_free, n_free;
    logic [IW-1:0]                  r_free_idx, n_free_idx;
    // output register
    logic [1:0]                     r_ostatus, n_ostatus;
    logic [cht_pkg::SLOT_W-1:0]     r_oslot, n_oslot;
    logic [cht_pkg::ADDR_W-1:0]     r_oaddr, n_oaddr;
    logic                           r_ole, n_ole;

    // memory port
    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_waddr;
    cht_pkg::t_entry  ram_wdata, ram_rdata;

    logic entry_live;
    logic out_free;

    cht_ram #(
        .WIDTH (cht_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tuser  = r_ostatus;
    assign m_tdata  = {2'b00, r_ole, r_oaddr, r_oslot};

    assign entry_live = r_valid[r_idx];
    assign out_free   = !r_ovalid || m_tready;

    // Scan sequencer and result build
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_ovalid   = r_ovalid;
        n_op       = r_op;
        n_key      = r_key;
        n_addr     = r_addr;
        n_le       = r_le;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_addr = r_hit_addr;
        n_hit_le   = r_hit_le;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_ostatus  = r_ostatus;
        n_oslot    = r_oslot;
        n_oaddr    = r_oaddr;
        n_ole      = r_ole;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_hit_idx;
        ram_wdata  = '{low_energy: r_le, addr: r_addr, handle: r_key};

        // drop the result once taken
        if (r_ovalid && m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // latch the item and start the scan at entry 0; a reserved op skips to S_FIN
                if (s_tvalid) begin
                    n_op    = s_tuser;
                    n_key   = s_tdata[11:0];
                    n_addr  = s_tdata[59:12];
                    n_le    = s_tdata[60];
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_state = (s_tuser == cht_pkg::OP_RSVD) ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                // compare the entry read last cycle
                if (entry_live && ram_rdata.handle == r_key) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_addr = ram_rdata.addr;
                    n_hit_le   = ram_rdata.low_energy;
                    n_state    = S_FIN;
                end else begin
                    if (!entry_live && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_FIN: begin
                // hold until the output register is free, then commit
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = cht_pkg::ST_MISS;
                    n_oslot   = '0;
                    n_oaddr   = '0;
                    n_ole     = 1'b0;
                    n_state   = S_IDLE;
                    unique case (r_op)
                        cht_pkg::OP_ADD: begin
                            if (r_hit) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_hit_idx;
                                n_ostatus = cht_pkg::ST_OK;
                                n_oslot   = cht_pkg::SLOT_W'(r_hit_idx);
                            end else if (r_free) begin
                                ram_we              = 1'b1;
                                ram_waddr           = r_free_idx;
                                n_valid[r_free_idx] = 1'b1;
                                n_ostatus           = cht_pkg::ST_OK;
                                n_oslot             = cht_pkg::SLOT_W'(r_free_idx);
                            end else begin
                                n_ostatus = cht_pkg::ST_FULL;
                            end
                        end
                        cht_pkg::OP_REMOVE: begin
                            if (r_hit) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_ostatus          = cht_pkg::ST_OK;
                                n_oslot            = cht_pkg::SLOT_W'(r_hit_idx);
                            end
                        end
                        cht_pkg::OP_LOOKUP: begin
                            if (r_hit) begin
                                n_ostatus = cht_pkg::ST_OK;
                                n_oslot   = cht_pkg::SLOT_W'(r_hit_idx);
                                n_oaddr   = r_hit_addr;
                                n_ole     = r_hit_le;
                            end
                        end
                        default: begin
                            n_ostatus = cht_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_addr     <= n_addr;
        r_le       <= n_le;
        r_idx      <= n_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_addr <= n_hit_addr;
        r_hit_le   <= n_hit_le;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_ostatus  <= n_ostatus;
        r_oslot    <= n_oslot;
        r_oaddr    <= n_oaddr;
        r_ole      <= n_ole;
    end

    // Checks
    `CHT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, m_tvalid, m_tuser <= cht_pkg::ST_FULL)
    `CHT_ASSERT_NOW(a_full_no_slot, i_clk, i_rst_n, m_tvalid && m_tuser != cht_pkg::ST_OK, m_tdata[4:0] == '0)
    `CHT_ASSERT_NEXT(a_write_marks_valid, i_clk, i_rst_n, ram_we, r_valid[$past(ram_waddr)])
    `CHT_ASSERT_NOW(a_result_from_fin, i_clk, i_rst_n, $rose(m_tvalid), $past(r_state) == S_FIN)

endmodule

`default_nettype wire

// ===== rtl/cht_ram.sv =====
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/connection_handle_table_tb.sv =====
`timescale 1ns / 100ps

module connection_handle_table_tb;

    localparam int TABLE_DEPTH = 32;
    localparam int POOL_SIZE   = 40;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HANDLE_W    = cht_pkg::HANDLE_W;
    localparam int ADDR_W      = cht_pkg::ADDR_W;
    localparam int SLOT_W      = cht_pkg::SLOT_W;

    // One result item as the table reports it
    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic              le;
    } link_result_t;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;              // handle[11:0], device_addr[59:12], low_energy[60]
    logic [1:0]  s_tuser  = cht_pkg::OP_ADD; // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;                    // slot[4:0], addr_out[52:5], low_energy_out[53]
    logic [1:0]  m_tuser;                    // status[1:0]

    // Shadow copy of the link table
    logic [TABLE_DEPTH-1:0] tbl_valid = '0;
    logic [HANDLE_W-1:0]    tbl_handle [TABLE_DEPTH];
    logic [ADDR_W-1:0]      tbl_addr   [TABLE_DEPTH];
    logic                   tbl_le     [TABLE_DEPTH];

    logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];
    link_result_t        expected_results [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  src_idle_en    = 1'b1;
    bit  sink_idle_en   = 1'b1;
    int  long_hold_reqs = 0;

    connection_handle_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("connection_handle_table_tb NOT OK");
            $finish;
        end
    end

    // Apply one command to the shadow table and return the result it yields
    function automatic link_result_t table_apply(input logic [1:0] op,
                                                 input logic [HANDLE_W-1:0] key,
                                                 input logic [ADDR_W-1:0] dev_addr,
                                                 input logic le);
        link_result_t r;
        int hit;
        r.status = cht_pkg::ST_MISS;
        r.slot   = '0;
        r.addr   = '0;
        r.le     = 1'b0;
        // lowest-indexed valid entry with a matching handle
        hit = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_handle[i] == key) hit = i;
        end
        case (op)
            cht_pkg::OP_ADD: begin
                // no match: claim the lowest free entry
                if (hit < 0) begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                        if (!tbl_valid[i]) hit = i;
                    end
                    if (hit >= 0) begin
                        tbl_valid[hit]  = 1'b1;
                        tbl_handle[hit] = key;
                    end
                end
                if (hit >= 0) begin
                    tbl_addr[hit] = dev_addr;
                    tbl_le[hit]   = le;
                    r.status      = cht_pkg::ST_OK;
                    r.slot        = hit[SLOT_W-1:0];
                end else begin
                    r.status = cht_pkg::ST_FULL;
                end
            end
            cht_pkg::OP_REMOVE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                    r.status       = cht_pkg::ST_OK;
                    r.slot         = hit[SLOT_W-1:0];
                end
            end
            cht_pkg::OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.status = cht_pkg::ST_OK;
                    r.slot   = hit[SLOT_W-1:0];
                    r.addr   = tbl_addr[hit];
                    r.le     = tbl_le[hit];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        a[47:32] = 16'($urandom_range(0, 16'hFFFF));
        a[31:0]  = $urandom();
        return a;
    endfunction

    function automatic logic [HANDLE_W-1:0] rand_handle();
        return HANDLE_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly handles from the shared pool, so that adds, hits and removes meet
    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 9) == 0) return rand_handle();
        return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Offer one item, hold it until accepted, then record its expected result
    task automatic issue_command(input logic [1:0] op, input logic [HANDLE_W-1:0] key,
                                 input logic [ADDR_W-1:0] dev_addr, input logic le);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, le, dev_addr, key};
        do @(posedge i_clk); while (!s_tready);
        expected_results.push_back(table_apply(op, key, dev_addr, le));
    endtask

    // Drop valid and wait until every outstanding result has arrived
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Check each result item; stall the output in random bursts or long holds
    initial begin : result_sink
        int           stall_left;
        int           holds_done;
        link_result_t want;
        link_result_t got;
        stall_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.slot   = m_tdata[4:0];
                got.addr   = m_tdata[52:5];
                got.le     = m_tdata[53];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected item: status %h slot %0d addr %h le %b",
                             $time, got.status, got.slot, got.addr, got.le);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.addr !== want.addr || got.le !== want.le) begin
                        mismatch_count++;
                        $display("%0t: expected status %h slot %0d addr %h le %b",
                                 $time, want.status, want.slot, want.addr, want.le);
                        $display("%0t: actual   status %h slot %0d addr %h le %b",
                                 $time, got.status, got.slot, got.addr, got.le);
                    end
                end
            end
            if (long_hold_reqs != holds_done) begin
                holds_done = long_hold_reqs;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && sink_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Misses on an empty table, reserved operation
    task automatic test_empty_table();
        issue_command(cht_pkg::OP_LOOKUP, 12'h000, '0, 1'b0);
        issue_command(cht_pkg::OP_REMOVE, 12'hFFF, '1, 1'b1);
        issue_command(cht_pkg::OP_RSVD, 12'hFFF, '1, 1'b1);
    endtask

    // Allocate, update, remove and reclaim with extreme field values
    task automatic test_add_update_remove();
        issue_command(cht_pkg::OP_ADD, 12'h000, '0, 1'b0);
        issue_command(cht_pkg::OP_ADD, 12'hFFF, '1, 1'b1);
        issue_command(cht_pkg::OP_LOOKUP, 12'hFFF, '0, 1'b0);
        issue_command(cht_pkg::OP_LOOKUP, 12'h000, '1, 1'b1);
        issue_command(cht_pkg::OP_ADD, 12'hFFF, 48'h5555_AAAA_0F0F, 1'b0);
        issue_command(cht_pkg::OP_LOOKUP, 12'hFFF, '0, 1'b0);
        issue_command(cht_pkg::OP_REMOVE, 12'h000, '0, 1'b0);
        issue_command(cht_pkg::OP_LOOKUP, 12'h000, '0, 1'b0);
        issue_command(cht_pkg::OP_REMOVE, 12'h000, '0, 1'b0);
        issue_command(cht_pkg::OP_ADD, 12'h800, 48'hAAAA_5555_F0F0, 1'b1);
        // reserved op on a present handle still misses
        issue_command(cht_pkg::OP_RSVD, 12'h800, '1, 1'b1);
        issue_command(cht_pkg::OP_LOOKUP, 12'h800, '0, 1'b0);
    endtask

    // Fill every entry, hit the full case, free one and reclaim it
    task automatic test_table_full();
        int idx;
        logic [HANDLE_W-1:0] key;
        while (!(&tbl_valid))
            issue_command(cht_pkg::OP_ADD, rand_handle(), rand_addr(), rand_bit());
        issue_command(cht_pkg::OP_ADD, rand_handle(), rand_addr(), 1'b1);
        idx = $urandom_range(0, TABLE_DEPTH - 1);
        issue_command(cht_pkg::OP_ADD, tbl_handle[idx], rand_addr(), rand_bit());
        issue_command(cht_pkg::OP_LOOKUP, tbl_handle[TABLE_DEPTH - 1], '0, 1'b0);
        idx = $urandom_range(1, TABLE_DEPTH - 2);
        key = tbl_handle[idx];
        issue_command(cht_pkg::OP_REMOVE, key, '0, 1'b0);
        issue_command(cht_pkg::OP_LOOKUP, key, '0, 1'b0);
        issue_command(cht_pkg::OP_ADD, rand_handle(), rand_addr(), 1'b0);
        issue_command(cht_pkg::OP_REMOVE, tbl_handle[TABLE_DEPTH - 1], '0, 1'b0);
        issue_command(cht_pkg::OP_ADD, rand_handle(), rand_addr(), 1'b1);
    endtask

    // Weighted random traffic over a handle pool, growing and shrinking phases
    task automatic test_random_traffic(input int n_items, input bit vary_idle);
        int add_pct;
        int rem_pct;
        int pick;
        for (int i = 0; i < POOL_SIZE; i++) handle_pool[i] = rand_handle();
        add_pct = 45;
        rem_pct = 20;
        for (int n = 0; n < n_items; n++) begin
            if (n % 150 == 0) begin
                if (vary_idle) begin
                    src_idle_en  = $urandom_range(0, 2) != 0;
                    sink_idle_en = $urandom_range(0, 2) != 0;
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_pct = 60;
                    rem_pct = 15;
                end else begin
                    add_pct = 20;
                    rem_pct = 50;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < add_pct)
                issue_command(cht_pkg::OP_ADD, pick_handle(), rand_addr(), rand_bit());
            else if (pick < add_pct + rem_pct)
                issue_command(cht_pkg::OP_REMOVE, pick_handle(), rand_addr(), rand_bit());
            else if (pick < 96)
                issue_command(cht_pkg::OP_LOOKUP, pick_handle(), rand_addr(), rand_bit());
            else
                issue_command(cht_pkg::OP_RSVD, pick_handle(), rand_addr(), rand_bit());
        end
    endtask

    // Hold the output off long enough that the input stalls, then drain fully
    task automatic test_output_backpressure();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        long_hold_reqs++;
        for (int n = 0; n < 10; n++)
            issue_command($urandom_range(0, 1) ? cht_pkg::OP_ADD : cht_pkg::OP_LOOKUP,
                          pick_handle(), rand_addr(), rand_bit());
        wait_results_drained();
        for (int n = 0; n < 6; n++)
            issue_command(cht_pkg::OP_LOOKUP, pick_handle(), '0, 1'b0);
    endtask

    // Closing stretch with no idling on either side
    task automatic test_no_idle_stream();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_traffic(300, 1'b0);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
    endtask

    initial begin : main_sequence
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_add_update_remove();
        test_table_full();
        test_random_traffic(1450, 1'b1);
        test_output_backpressure();
        test_no_idle_stream();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("connection_handle_table_tb OK");
        end else begin
            $display("connection_handle_table_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== connection_handle_table.f =====
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/connection_handle_table.sv
dv/connection_handle_table_tb.sv
